FILE: rtl/core/mrcf_pkg.sv
// Shared types, constants and the CRC-16 step for the Modbus RTU command framer.
package mrcf_pkg;

    // Reply length in bytes, including the two CRC bytes.
    localparam logic [3:0] REPLY_LENGTH  = 4'd8;
    localparam logic [3:0] REPLY_CRC_END = REPLY_LENGTH - 4'd2;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    localparam logic [7:0] FC_WRITE_REG   = 8'h06;
    localparam logic [7:0] FC_WRITE_COILS = 8'h0F;
    localparam logic [7:0] COIL_COUNT     = 8'h03;
    localparam logic [7:0] COIL_BYTES     = 8'h01;
    localparam logic [7:0] RELAY_MAX_BITS = 8'h07;
    localparam logic [7:0] RELAY_ALL_OFF  = 8'd11;

    localparam logic [3:0] POWER_BODY_LEN = 4'd6;
    localparam logic [3:0] RELAY_BODY_LEN = 4'd8;

    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 16;
    localparam logic [CFG_INDEX_W-1:0] CFG_DEVICE_ADDRESS = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_POWER_REGISTER = 8'd1;

    localparam logic [7:0]  DEVICE_ADDRESS_RESET = 8'd1;
    localparam logic [15:0] POWER_REGISTER_RESET = 16'd3000;

    localparam logic signed [16:0] POWER_NONE   = -17'sd1;
    localparam logic [7:0]         STATE_UNKNOWN = 8'd255;

    typedef enum logic [1:0] {
        FUNC_POWER = 2'd0,
        FUNC_RELAY = 2'd1,
        FUNC_RX    = 2'd2,
        FUNC_END   = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        ERR_OK          = 2'd0,
        ERR_BAD_STATE   = 2'd1,
        ERR_BAD_CRC     = 2'd2,
        ERR_SHORT_REPLY = 2'd3
    } err_t;

    typedef enum logic [2:0] {
        PEND_NONE  = 3'b001,
        PEND_POWER = 3'b010,
        PEND_RELAY = 3'b100
    } pend_t;

    typedef enum logic [1:0] {
        JOB_POWER   = 2'd0,
        JOB_RELAY   = 2'd1,
        JOB_VERDICT = 2'd2
    } job_kind_t;

    typedef struct packed {
        job_kind_t          kind;
        logic [15:0]        watts;
        logic [2:0]         bits;
        err_t               err;
        logic signed [16:0] conf_power;
        logic [7:0]         conf_state;
        logic [2:0]         conf_bits;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    typedef struct packed {
        logic               kind;
        logic [7:0]         tx_byte;
        logic               last;
        err_t               err;
        logic signed [16:0] conf_power;
        logic [7:0]         conf_state;
        logic [2:0]         conf_bits;
    } result_t;

    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

FILE: rtl/core/mrcf_front.sv
// Front end: accept items, track the pending reply and push one job per result run.
module mrcf_front import mrcf_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        item_valid,
    input  func_t       item_func,
    input  logic [15:0] item_watts,
    input  logic [7:0]  item_state,
    input  logic [7:0]  item_rx,
    output logic        push,
    output job_t        push_job
);

    pend_t              pending_kind_reg,  pending_kind_next;
    logic [15:0]        pending_watts_reg, pending_watts_next;
    logic [7:0]         pending_state_reg, pending_state_next;
    logic [2:0]         pending_bits_reg,  pending_bits_next;
    logic [3:0]         reply_count_reg,   reply_count_next;
    logic [15:0]        reply_crc_reg,     reply_crc_next;
    logic [7:0]         reply_crc_low_reg, reply_crc_low_next;
    logic signed [16:0] conf_power_reg,    conf_power_next;
    logic [7:0]         conf_state_reg,    conf_state_next;
    logic [2:0]         conf_bits_reg,     conf_bits_next;

    logic [3:0]  count_inc;
    logic        state_ok;
    logic [2:0]  state_bits;

    assign count_inc  = reply_count_reg + 4'd1;
    assign state_ok   = (item_state <= RELAY_MAX_BITS) || (item_state == RELAY_ALL_OFF);
    assign state_bits = (item_state <= RELAY_MAX_BITS) ? item_state[2:0] : 3'd0;

    always_comb begin
        pending_kind_next  = pending_kind_reg;
        pending_watts_next = pending_watts_reg;
        pending_state_next = pending_state_reg;
        pending_bits_next  = pending_bits_reg;
        reply_count_next   = reply_count_reg;
        reply_crc_next     = reply_crc_reg;
        reply_crc_low_next = reply_crc_low_reg;
        conf_power_next    = conf_power_reg;
        conf_state_next    = conf_state_reg;
        conf_bits_next     = conf_bits_reg;
        push               = 1'b0;
        push_job.kind      = JOB_VERDICT;
        push_job.watts     = item_watts;
        push_job.bits      = state_bits;
        push_job.err       = ERR_OK;

        if (item_valid) begin
            case (item_func)
                FUNC_POWER: begin
                    push               = 1'b1;
                    push_job.kind      = JOB_POWER;
                    pending_kind_next  = PEND_POWER;
                    pending_watts_next = item_watts;
                    reply_count_next   = 4'd0;
                    reply_crc_next     = CRC_INIT;
                    reply_crc_low_next = 8'd0;
                end
                FUNC_RELAY: begin
                    push = 1'b1;
                    if (state_ok) begin
                        push_job.kind      = JOB_RELAY;
                        pending_kind_next  = PEND_RELAY;
                        pending_state_next = item_state;
                        pending_bits_next  = state_bits;
                        reply_count_next   = 4'd0;
                        reply_crc_next     = CRC_INIT;
                        reply_crc_low_next = 8'd0;
                    end else begin
                        push_job.err = ERR_BAD_STATE;
                    end
                end
                FUNC_RX: begin
                    if (pending_kind_reg != PEND_NONE) begin
                        if (reply_count_reg < REPLY_CRC_END) begin
                            reply_crc_next = crc16_byte(reply_crc_reg, item_rx);
                        end else if (reply_count_reg == REPLY_CRC_END) begin
                            reply_crc_low_next = item_rx;
                        end
                        reply_count_next = count_inc;
                        if (count_inc == REPLY_LENGTH) begin
                            // Judge the reply: power needs a CRC match, relay only length.
                            push              = 1'b1;
                            pending_kind_next = PEND_NONE;
                            if (pending_kind_reg == PEND_POWER) begin
                                if ({item_rx, reply_crc_low_reg} == reply_crc_reg) begin
                                    conf_power_next = $signed({1'b0, pending_watts_reg});
                                end else begin
                                    push_job.err = ERR_BAD_CRC;
                                end
                            end else begin
                                conf_state_next = pending_state_reg;
                                conf_bits_next  = pending_bits_reg;
                            end
                        end
                    end
                end
                FUNC_END: begin
                    if ((pending_kind_reg != PEND_NONE) && (reply_count_reg < REPLY_LENGTH)) begin
                        push              = 1'b1;
                        push_job.err      = ERR_SHORT_REPLY;
                        pending_kind_next = PEND_NONE;
                    end
                end
                default: begin
                    push = 1'b0;
                end
            endcase
        end

        push_job.conf_power = conf_power_next;
        push_job.conf_state = conf_state_next;
        push_job.conf_bits  = conf_bits_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_kind_reg  <= PEND_NONE;
            pending_watts_reg <= 16'd0;
            pending_state_reg <= 8'd0;
            pending_bits_reg  <= 3'd0;
            reply_count_reg   <= 4'd0;
            reply_crc_reg     <= CRC_INIT;
            reply_crc_low_reg <= 8'd0;
            conf_power_reg    <= POWER_NONE;
            conf_state_reg    <= STATE_UNKNOWN;
            conf_bits_reg     <= 3'd0;
        end else begin
            pending_kind_reg  <= pending_kind_next;
            pending_watts_reg <= pending_watts_next;
            pending_state_reg <= pending_state_next;
            pending_bits_reg  <= pending_bits_next;
            reply_count_reg   <= reply_count_next;
            reply_crc_reg     <= reply_crc_next;
            reply_crc_low_reg <= reply_crc_low_next;
            conf_power_reg    <= conf_power_next;
            conf_state_reg    <= conf_state_next;
            conf_bits_reg     <= conf_bits_next;
        end
    end

endmodule

FILE: rtl/core/mrcf_queue.sv
// Small job queue between the front end and the frame emitter.
module mrcf_queue import mrcf_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    push,
    input  job_t    push_job,
    input  logic    pop,
    output job_t    head,
    output q_stat_t stat
);

    job_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg,  count_next;
    logic              do_push, do_pop;

    assign stat.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign stat.empty = (count_reg == '0);
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign head       = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = do_push ? (wr_ptr_reg + QPTR_W'(1)) : wr_ptr_reg;
        rd_ptr_next = do_pop  ? (rd_ptr_reg + QPTR_W'(1)) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + QCNT_W'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

FILE: rtl/core/mrcf_back.sv
// Back end: expand queued jobs into frame bytes with running CRC, or single verdicts.
module mrcf_back import mrcf_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic [7:0]  device_address,
    input  logic [15:0] power_register,
    input  job_t        head,
    input  q_stat_t     stat,
    output logic        pop,
    output logic        out_valid,
    output result_t     out_data,
    input  logic        out_ready
);

    logic [3:0]  idx_reg, idx_next;
    logic [15:0] crc_reg, crc_next;
    logic        out_valid_reg, out_valid_next;
    result_t     out_data_reg;
    result_t     res;
    logic        load;
    logic [3:0]  body_len;
    logic [7:0]  body_byte;

    assign load     = !stat.empty && (!out_valid_reg || out_ready);
    assign body_len = (head.kind == JOB_POWER) ? POWER_BODY_LEN : RELAY_BODY_LEN;

    always_comb begin
        body_byte = 8'd0;
        if (head.kind == JOB_POWER) begin
            case (idx_reg)
                4'd0:    body_byte = device_address;
                4'd1:    body_byte = FC_WRITE_REG;
                4'd2:    body_byte = power_register[15:8];
                4'd3:    body_byte = power_register[7:0];
                4'd4:    body_byte = head.watts[15:8];
                4'd5:    body_byte = head.watts[7:0];
                default: body_byte = 8'd0;
            endcase
        end else begin
            case (idx_reg)
                4'd0:    body_byte = device_address;
                4'd1:    body_byte = FC_WRITE_COILS;
                4'd5:    body_byte = COIL_COUNT;
                4'd6:    body_byte = COIL_BYTES;
                4'd7:    body_byte = {5'd0, head.bits};
                default: body_byte = 8'd0;
            endcase
        end
    end

    always_comb begin
        idx_next       = idx_reg;
        crc_next       = crc_reg;
        pop            = 1'b0;
        res.kind       = 1'b0;
        res.tx_byte    = 8'd0;
        res.last       = 1'b0;
        res.err        = ERR_OK;
        res.conf_power = head.conf_power;
        res.conf_state = head.conf_state;
        res.conf_bits  = head.conf_bits;

        if (head.kind == JOB_VERDICT) begin
            res.kind = 1'b1;
            res.last = 1'b1;
            res.err  = head.err;
            if (load) begin
                pop = 1'b1;
            end
        end else if (idx_reg < body_len) begin
            res.tx_byte = body_byte;
            if (load) begin
                crc_next = crc16_byte(crc_reg, body_byte);
                idx_next = idx_reg + 4'd1;
            end
        end else if (idx_reg == body_len) begin
            res.tx_byte = crc_reg[7:0];
            if (load) begin
                idx_next = idx_reg + 4'd1;
            end
        end else begin
            res.tx_byte = crc_reg[15:8];
            res.last    = 1'b1;
            if (load) begin
                pop      = 1'b1;
                idx_next = 4'd0;
                crc_next = CRC_INIT;
            end
        end

        out_valid_next = out_valid_reg;
        if (load) begin
            out_valid_next = 1'b1;
        end else if (out_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg       <= 4'd0;
            crc_reg       <= CRC_INIT;
            out_valid_reg <= 1'b0;
        end else begin
            idx_reg       <= idx_next;
            crc_reg       <= crc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            out_data_reg <= res;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

FILE: rtl/core/modbus_rtu_command_framer_unit.sv
// Top level of the Modbus RTU command framer: ports, configuration registers, assertions.
//
// Input stream (s_*): one transaction per command or reply event. s_tuser carries the
// function (power command, relay command, reply byte, reply window end); s_tdata carries
// the setpoint, the relay state and the received byte.
// Output stream (m_*): one transaction per frame byte or verdict. m_tuser is 0 for a byte
// to transmit and 1 for a verdict; m_tlast marks the final CRC byte of a frame and every
// verdict. Each transaction also reports the confirmed power and relay values.
// Configuration channel (cfg_*): writes the slave address (index 0) and the power holding
// register (index 1); cfg_ready is always high. Write only while the block is idle.
// An item's job passes through the job queue and then the output register to m_tvalid.
// Throughput: one result per cycle unless m_tready stalls; a power command yields 8 results,
// a valid relay command 10, a verdict 1. The front end takes one item per cycle while its
// 4-entry job queue has room, so the output port sets the sustained rate.
// Reset (aresetn low, synchronous): drop all queued work, forget any pending reply, set
// confirmed power to -1, relay state to 255, and the registers to address 1, register 3000.
// When the receiver stalls, the output register holds its transaction, the emitter holds,
// and s_tready falls once the job queue fills.
module modbus_rtu_command_framer_unit import mrcf_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // [15:0] power_watts, [23:16] relay_state, [31:24] rx_byte
    input  logic [31:0]            s_tdata,
    // [1:0] func
    input  logic [1:0]             s_tuser,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // [7:0] tx_byte, [9:8] error_code, [26:10] last_power_watts,
    // [34:27] relay_state_now, [37:35] relay_bits_now, [39:38] zero
    output logic [39:0]            m_tdata,
    // [0] kind
    output logic                   m_tuser,
    output logic                   m_tlast,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    logic [7:0]  device_address_reg;
    logic [15:0] power_register_reg;

    logic    item_valid;
    logic    q_push;
    job_t    q_push_job;
    logic    q_pop;
    job_t    q_head;
    q_stat_t q_stat;
    logic    out_valid;
    result_t out_data;

    // Configuration registers; writes to other indexes are dropped.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            device_address_reg <= DEVICE_ADDRESS_RESET;
            power_register_reg <= POWER_REGISTER_RESET;
        end else if (cfg_valid && cfg_ready) begin
            if (cfg_index == CFG_DEVICE_ADDRESS) begin
                device_address_reg <= cfg_data[7:0];
            end else if (cfg_index == CFG_POWER_REGISTER) begin
                power_register_reg <= cfg_data;
            end
        end
    end

    // Each accepted item pushes at most one job, so room for one entry is enough.
    assign s_tready   = !q_stat.full;
    assign item_valid = s_tvalid && s_tready;

    mrcf_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (item_valid),
        .item_func  (func_t'(s_tuser)),
        .item_watts (s_tdata[15:0]),
        .item_state (s_tdata[23:16]),
        .item_rx    (s_tdata[31:24]),
        .push       (q_push),
        .push_job   (q_push_job)
    );

    mrcf_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_job (q_push_job),
        .pop      (q_pop),
        .head     (q_head),
        .stat     (q_stat)
    );

    mrcf_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .device_address (device_address_reg),
        .power_register (power_register_reg),
        .head           (q_head),
        .stat           (q_stat),
        .pop            (q_pop),
        .out_valid      (out_valid),
        .out_data       (out_data),
        .out_ready      (m_tready)
    );

    // Pack the result register onto the output stream.
    assign m_tvalid = out_valid;
    assign m_tuser  = out_data.kind;
    assign m_tlast  = out_data.last;
    assign m_tdata  = {2'b00, out_data.conf_bits, out_data.conf_state,
                       out_data.conf_power, out_data.err, out_data.tx_byte};

`ifndef SYNTHESIS
    // A job never arrives at a full queue.
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        q_stat.full |-> !q_push)
        else $error("job pushed into full queue");

    // Verdicts are single-result runs with no transmit byte.
    a_verdict_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tlast && (m_tdata[7:0] == 8'd0)))
        else $error("malformed verdict");

    // Transmit bytes never carry an error code.
    a_tx_no_error: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> (m_tdata[9:8] == ERR_OK))
        else $error("error code on transmit byte");

    // A pop only happens when the output register is loaded from a queued job.
    a_pop_has_job: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |=> m_tvalid)
        else $error("queue popped without a result");
`endif

endmodule
